### src/atr_pkg.sv
// Shared types and codes for the smart card ATR parser.
// No dependencies; imported by atr_step and smart_card_atr_parser.
package atr_pkg;

   // Default bound on ATR buffer length
   localparam int AtrMaxDefault = 33;

   // Parse phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_T0    = 3'd1;
   localparam logic [2:0] PH_IFACE = 3'd2;
   localparam logic [2:0] PH_HIST  = 3'd3;
   localparam logic [2:0] PH_TCK   = 3'd4;

   // Result status codes
   localparam logic [2:0] ST_MORE  = 3'd0;
   localparam logic [2:0] ST_DONE  = 3'd1;
   localparam logic [2:0] ST_BADTS = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_FAIL  = 3'd4;

   // Byte kinds
   localparam logic [2:0] KIND_TS    = 3'd0;
   localparam logic [2:0] KIND_T0    = 3'd1;
   localparam logic [2:0] KIND_IFACE = 3'd2;
   localparam logic [2:0] KIND_HIST  = 3'd3;
   localparam logic [2:0] KIND_TCK   = 3'd4;

   // Input commands
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // TS values
   localparam logic [7:0] TS_DIRECT  = 8'h3B;
   localparam logic [7:0] TS_INVERSE = 8'h3F;

   // Parser state carried from item to item
   typedef struct packed {
      logic [2:0] phase;
      logic [2:0] group_left;
      logic       group_has_td;
      logic [3:0] hist_left;
      logic [3:0] proto;
      logic [5:0] byte_count;
      logic       convention;
   } atr_state_type;

   // One result item
   typedef struct packed {
      logic [2:0] status;
      logic [2:0] byte_kind;
      logic [5:0] byte_index;
      logic [5:0] atr_length;
      logic [3:0] protocol;
      logic       inverse_convention;
   } atr_result_type;

endpackage

### src/atr_step.sv
// Combinational next-state and result logic for one ATR item.
// Depends on atr_pkg.
module atr_step
   import atr_pkg::*;
#(
   parameter int ATR_MAX = AtrMaxDefault
) (
   input  atr_state_type  cur,
   input  logic           command,
   input  logic [7:0]     data_byte,
   output atr_state_type  nxt,
   output atr_result_type result
);

   localparam logic [6:0] MaxLen = 7'(ATR_MAX);

   logic [2:0] ph;
   logic [2:0] status;
   logic [2:0] kind;
   logic [5:0] index;
   logic [2:0] gl_dec;
   logic [3:0] hl_dec;
   logic [2:0] cnt;
   logic       do_group;
   logic       do_hist;
   logic       do_tck;

   // Interface byte count announced by the high nibble
   assign cnt = 3'(data_byte[4]) + 3'(data_byte[5]) + 3'(data_byte[6]) + 3'(data_byte[7]);
   assign gl_dec = (cur.group_left != 3'd0) ? cur.group_left - 3'd1 : 3'd0;
   assign hl_dec = (cur.hist_left != 4'd0) ? cur.hist_left - 4'd1 : 4'd0;

   always_comb begin
      nxt      = cur;
      status   = ST_MORE;
      kind     = KIND_TS;
      index    = 6'd0;
      do_group = 1'b0;
      do_hist  = 1'b0;
      do_tck   = 1'b0;
      ph       = (cur.phase > PH_TCK) ? PH_IDLE : cur.phase;
      nxt.phase = ph;

      // Byte classification
      if (command == CMD_TIMEOUT) begin
         status    = ST_FAIL;
         nxt.phase = PH_IDLE;
      end else if (ph == PH_IDLE) begin
         if (data_byte == TS_DIRECT || data_byte == TS_INVERSE) begin
            nxt.group_left   = 3'd0;
            nxt.group_has_td = 1'b0;
            nxt.hist_left    = 4'd0;
            nxt.proto        = 4'd0;
            nxt.convention   = (data_byte == TS_INVERSE);
            nxt.byte_count   = 6'd1;
            nxt.phase        = PH_T0;
         end else begin
            nxt    = '0;
            status = ST_BADTS;
         end
      end else begin
         index          = cur.byte_count;
         nxt.byte_count = cur.byte_count + 6'd1;
         case (ph)
            PH_T0: begin
               kind          = KIND_T0;
               nxt.hist_left = data_byte[3:0];
               do_group      = 1'b1;
            end
            PH_IFACE: begin
               kind           = KIND_IFACE;
               nxt.group_left = gl_dec;
               if (gl_dec == 3'd0) begin
                  if (cur.group_has_td) begin
                     nxt.proto = data_byte[3:0];
                     do_group  = 1'b1;
                  end else begin
                     do_hist = 1'b1;
                  end
               end
            end
            PH_HIST: begin
               kind          = KIND_HIST;
               nxt.hist_left = hl_dec;
               if (hl_dec == 4'd0) begin
                  do_tck = 1'b1;
               end
            end
            default: begin
               kind      = KIND_TCK;
               nxt.phase = PH_IDLE;
               status    = ST_DONE;
            end
         endcase
      end

      // Next interface group, with buffer bound check
      if (do_group) begin
         if (cnt == 3'd0) begin
            do_hist = 1'b1;
         end else if ({1'b0, nxt.byte_count} + {4'd0, cnt} > MaxLen) begin
            nxt.phase = PH_IDLE;
            status    = ST_OVER;
         end else begin
            nxt.group_left   = cnt;
            nxt.group_has_td = data_byte[7];
            nxt.phase        = PH_IFACE;
         end
      end

      // Historical bytes, with buffer bound check
      if (do_hist) begin
         if ({1'b0, nxt.byte_count} + {3'd0, nxt.hist_left} > MaxLen) begin
            nxt.phase = PH_IDLE;
            status    = ST_OVER;
         end else if (nxt.hist_left != 4'd0) begin
            nxt.phase = PH_HIST;
         end else begin
            do_tck = 1'b1;
         end
      end

      // TCK only when a non-zero protocol was announced
      if (do_tck) begin
         if (nxt.proto != 4'd0) begin
            if ({1'b0, nxt.byte_count} + 7'd1 > MaxLen) begin
               nxt.phase = PH_IDLE;
               status    = ST_OVER;
            end else begin
               nxt.phase = PH_TCK;
            end
         end else begin
            nxt.phase = PH_IDLE;
            status    = ST_DONE;
         end
      end
   end

   assign result.status             = status;
   assign result.byte_kind          = kind;
   assign result.byte_index         = index;
   assign result.atr_length         = nxt.byte_count;
   assign result.protocol           = nxt.proto;
   assign result.inverse_convention = nxt.convention;

endmodule

### src/smart_card_atr_parser.sv
// Smart card Answer-To-Reset parser: input register, parse step, result register.
// Depends on atr_pkg and atr_step.
//
// Usage:
//   Each req_ item is one card event: req_command 0 carries a received byte in
//   req_data_byte, req_command 1 reports a read timeout. Every item yields
//   exactly one rsp_ item with the parse status, the byte kind and position,
//   the running ATR length, the current protocol and the convention.
//   An item is taken on a clock edge with valid high and stall low.
//   An accepted item passes the input register, then the result register,
//   before its rsp_valid rises. Throughput is one item per cycle while
//   rsp_stall is low; the parse decision is a single pass of logic between
//   the two registers, with the parser state updated as an item moves into
//   the result register.
//   When the receiver holds rsp_stall, the result holds, one more item waits
//   in the input register, and req_stall rises after that.
//   Synchronous reset empties both registers and returns the parser to idle,
//   awaiting TS, with all counts, protocol and convention cleared.
module smart_card_atr_parser
   import atr_pkg::*;
#(
   parameter int ATR_MAX = AtrMaxDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_byte_kind,
   output logic [5:0] rsp_byte_index,
   output logic [5:0] rsp_atr_length,
   output logic [3:0] rsp_protocol,
   output logic       rsp_inverse_convention
);

   logic           in_valid_ff,  in_valid_in;
   logic           in_cmd_ff;
   logic [7:0]     in_data_ff;
   atr_state_type  state_ff,     state_in;
   logic           out_valid_ff, out_valid_in;
   atr_result_type out_ff;
   atr_result_type step_result;
   logic           out_free;
   logic           advance;
   logic           in_load;

   // Flow control between the two registers
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   // Parse step on the registered item
   atr_step #(
      .ATR_MAX(ATR_MAX)
   ) u_step (
      .cur      (state_ff),
      .command  (in_cmd_ff),
      .data_byte(in_data_ff),
      .nxt      (state_in),
      .result   (step_result)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_cmd_ff  <= req_command;
         in_data_ff <= req_data_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_status             = out_ff.status;
   assign rsp_byte_kind          = out_ff.byte_kind;
   assign rsp_byte_index         = out_ff.byte_index;
   assign rsp_atr_length         = out_ff.atr_length;
   assign rsp_protocol           = out_ff.protocol;
   assign rsp_inverse_convention = out_ff.inverse_convention;

endmodule

### bench/tb_smart_card_atr_parser.sv
// Testbench for smart_card_atr_parser: directed ATR table, then random ATR streams.
// Each result is checked against the table's expected row where one is given, else
// against a cycle-free parse predictor. Depends on atr_pkg and the parser RTL.
module tb_smart_card_atr_parser;
   import atr_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_command;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_status;
   logic [2:0] rsp_byte_kind;
   logic [5:0] rsp_byte_index;
   logic [5:0] rsp_atr_length;
   logic [3:0] rsp_protocol;
   logic       rsp_inverse_convention;

   smart_card_atr_parser dut (.*);

   // one row of the directed table; want is only used when typed is set
   typedef struct {
      logic           cmd;
      logic [7:0]     data;
      bit             typed;
      atr_result_type want;
   } atr_row_type;

   localparam int DirRows = 22;
   localparam int RandItems = 1300;

   atr_row_type dir_rows [DirRows] = '{
      // timeout and bad TS straight out of reset
      '{CMD_TIMEOUT, 8'h00, 1'b1, {ST_FAIL, KIND_TS, 6'd0, 6'd0, 4'd0, 1'b0}},
      '{CMD_BYTE, 8'h00, 1'b1, {ST_BADTS, KIND_TS, 6'd0, 6'd0, 4'd0, 1'b0}},
      '{CMD_BYTE, 8'hFF, 1'b1, {ST_BADTS, KIND_TS, 6'd0, 6'd0, 4'd0, 1'b0}},
      // shortest ATR, inverse convention: TS, empty T0
      '{CMD_BYTE, TS_INVERSE, 1'b1, {ST_MORE, KIND_TS, 6'd0, 6'd1, 4'd0, 1'b1}},
      '{CMD_BYTE, 8'h00, 1'b1, {ST_DONE, KIND_T0, 6'd1, 6'd2, 4'd0, 1'b1}},
      // full group, TD chain, historical bytes and TCK
      '{CMD_BYTE, TS_DIRECT, 1'b1, {ST_MORE, KIND_TS, 6'd0, 6'd1, 4'd0, 1'b0}},
      '{CMD_BYTE, 8'hF5, 1'b0, '0},
      '{CMD_BYTE, 8'h11, 1'b0, '0},
      '{CMD_BYTE, 8'h22, 1'b0, '0},
      '{CMD_BYTE, 8'h33, 1'b0, '0},
      '{CMD_BYTE, 8'h81, 1'b0, '0},
      '{CMD_BYTE, 8'h0F, 1'b0, '0},
      '{CMD_BYTE, 8'h00, 1'b0, '0},
      '{CMD_BYTE, 8'hFF, 1'b0, '0},
      '{CMD_BYTE, 8'h55, 1'b0, '0},
      '{CMD_BYTE, 8'hAA, 1'b0, '0},
      '{CMD_BYTE, 8'h80, 1'b0, '0},
      '{CMD_BYTE, 8'h12, 1'b0, '0},
      // timeout in the middle of an ATR
      '{CMD_BYTE, TS_DIRECT, 1'b1, {ST_MORE, KIND_TS, 6'd0, 6'd1, 4'd0, 1'b0}},
      '{CMD_BYTE, 8'h80, 1'b0, '0},
      '{CMD_BYTE, 8'h90, 1'b0, '0},
      '{CMD_TIMEOUT, 8'hA5, 1'b1, {ST_FAIL, KIND_TS, 6'd0, 6'd3, 4'd0, 1'b0}}
   };

   atr_state_type  parse_st = '0;
   atr_result_type pending_results [$];
   int             fail_count = 0;
   int             sent_count = 0;
   int             cycle_count = 0;
   int             stall_left = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // --- parse predictor ---

   // TCK is due only when a nonzero protocol was announced
   function automatic logic [2:0] tck_due();
      if (parse_st.proto != 4'd0) begin
         if (int'(parse_st.byte_count) + 1 > AtrMaxDefault) begin
            parse_st.phase = PH_IDLE;
            return ST_OVER;
         end
         parse_st.phase = PH_TCK;
         return ST_MORE;
      end
      parse_st.phase = PH_IDLE;
      return ST_DONE;
   endfunction

   function automatic logic [2:0] hist_due();
      if (int'(parse_st.byte_count) + int'(parse_st.hist_left) > AtrMaxDefault) begin
         parse_st.phase = PH_IDLE;
         return ST_OVER;
      end
      if (parse_st.hist_left != 4'd0) begin
         parse_st.phase = PH_HIST;
         return ST_MORE;
      end
      return tck_due();
   endfunction

   // high nibble of T0 or TD announces the next interface group
   function automatic logic [2:0] open_group(logic [7:0] ind);
      int cnt;
      cnt = $countones(ind[7:4]);
      if (cnt == 0)
         return hist_due();
      if (int'(parse_st.byte_count) + cnt > AtrMaxDefault) begin
         parse_st.phase = PH_IDLE;
         return ST_OVER;
      end
      parse_st.group_left = 3'(cnt);
      parse_st.group_has_td = ind[7];
      parse_st.phase = PH_IFACE;
      return ST_MORE;
   endfunction

   function automatic atr_result_type parse_atr_byte(logic cmd, logic [7:0] data);
      atr_result_type r;
      r = '0;
      r.status = ST_MORE;
      r.byte_kind = KIND_TS;
      if (parse_st.phase > PH_TCK)
         parse_st.phase = PH_IDLE;
      if (cmd == CMD_TIMEOUT) begin
         r.status = ST_FAIL;
         parse_st.phase = PH_IDLE;
      end else if (parse_st.phase == PH_IDLE) begin
         // any byte in idle is a TS candidate
         parse_st = '0;
         if (data == TS_DIRECT || data == TS_INVERSE) begin
            parse_st.convention = (data == TS_INVERSE);
            parse_st.byte_count = 6'd1;
            parse_st.phase = PH_T0;
         end else begin
            r.status = ST_BADTS;
         end
      end else begin
         r.byte_index = parse_st.byte_count;
         parse_st.byte_count = parse_st.byte_count + 6'd1;
         case (parse_st.phase)
            PH_T0: begin
               r.byte_kind = KIND_T0;
               parse_st.hist_left = data[3:0];
               r.status = open_group(data);
            end
            PH_IFACE: begin
               r.byte_kind = KIND_IFACE;
               if (parse_st.group_left != 3'd0)
                  parse_st.group_left = parse_st.group_left - 3'd1;
               if (parse_st.group_left == 3'd0) begin
                  if (parse_st.group_has_td) begin
                     parse_st.proto = data[3:0];
                     r.status = open_group(data);
                  end else begin
                     r.status = hist_due();
                  end
               end
            end
            PH_HIST: begin
               r.byte_kind = KIND_HIST;
               if (parse_st.hist_left != 4'd0)
                  parse_st.hist_left = parse_st.hist_left - 4'd1;
               if (parse_st.hist_left == 4'd0)
                  r.status = tck_due();
            end
            default: begin
               r.byte_kind = KIND_TCK;
               parse_st.phase = PH_IDLE;
               r.status = ST_DONE;
            end
         endcase
      end
      r.atr_length = parse_st.byte_count;
      r.protocol = parse_st.proto;
      r.inverse_convention = parse_st.convention;
      return r;
   endfunction

   // --- sender ---

   // drive one item, wait for it to be taken, record its expected result, then maybe idle
   task automatic send_item(logic cmd, logic [7:0] data, bit typed, atr_result_type want);
      atr_result_type predicted;
      int gap;
      int roll;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall);
      predicted = parse_atr_byte(cmd, data);
      pending_results.push_back(typed ? want : predicted);
      sent_count++;
      // stretches without gaps, otherwise mostly short gaps and a few long ones
      gap = 0;
      roll = $urandom_range(0, 99);
      if ((sent_count / 150) % 3 != 0) begin
         if (roll >= 95)
            gap = $urandom_range(8, 40);
         else if (roll >= 55)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random item, mostly well-formed ATRs with long TD chains
   task automatic send_random();
      logic       cmd;
      logic [7:0] data;
      int         roll;
      cmd = CMD_BYTE;
      data = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         cmd = CMD_TIMEOUT;
      end else if (parse_st.phase == PH_IDLE) begin
         if (roll < 90)
            data = $urandom_range(0, 1) ? TS_INVERSE : TS_DIRECT;
      end else if (parse_st.phase == PH_T0 ||
                   (parse_st.phase == PH_IFACE && parse_st.group_left == 3'd1 &&
                    parse_st.group_has_td)) begin
         // bias the announcing byte toward chaining another group
         if (roll < 88)
            data[7] = 1'b1;
      end
      send_item(cmd, data, 1'b0, '0);
   endtask

   // drain all outstanding results with the sender idle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_BYTE;
      req_data_byte <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirRows; i++)
         send_item(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      drain_results();

      for (int i = 0; i < RandItems; i++) begin
         send_random();
         if (i == RandItems / 2)
            drain_results();
      end
      drain_results();

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb_smart_card_atr_parser: done, clean");
      else
         $display("tb_smart_card_atr_parser: done, errors");
      $finish;
   end

   // --- receiver: check taken results, then pick the next stall ---
   initial begin
      atr_result_type want;
      int roll;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result item with none expected");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_byte_kind !== want.byte_kind) begin
                  $error("byte_kind: expected %0d, got %0d", want.byte_kind, rsp_byte_kind);
                  fail_count++;
               end
               if (rsp_byte_index !== want.byte_index) begin
                  $error("byte_index: expected %0d, got %0d", want.byte_index,
                         rsp_byte_index);
                  fail_count++;
               end
               if (rsp_atr_length !== want.atr_length) begin
                  $error("atr_length: expected %0d, got %0d", want.atr_length,
                         rsp_atr_length);
                  fail_count++;
               end
               if (rsp_protocol !== want.protocol) begin
                  $error("protocol: expected %0d, got %0d", want.protocol, rsp_protocol);
                  fail_count++;
               end
               if (rsp_inverse_convention !== want.inverse_convention) begin
                  $error("inverse_convention: expected %0d, got %0d",
                         want.inverse_convention, rsp_inverse_convention);
                  fail_count++;
               end
            end
         end
         // stall: free-running stretches, else mostly short holds and a few long ones
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if ((cycle_count / 300) % 4 == 0 || roll < 70) begin
               rsp_stall <= 1'b0;
            end else begin
               stall_left = (roll >= 95) ? $urandom_range(10, 40) - 1 : $urandom_range(1, 3) - 1;
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // run limit
   initial begin
      #2_500_000;
      $display("tb_smart_card_atr_parser: done, errors");
      $finish;
   end

endmodule

### files.f
src/atr_pkg.sv
src/atr_step.sv
src/smart_card_atr_parser.sv
bench/tb_smart_card_atr_parser.sv
